@@ rtl/core/dhft_pkg.sv @@
// ----------------------------------------------------------------------------
// dhft_pkg
// shared types, constants and character helpers for the binary64 hex text unit
// ----------------------------------------------------------------------------
package dhft_pkg;

  localparam int BitsW   = 64;
  localparam int FracW   = 52;
  localparam int ExpW    = 11;
  localparam int MagW    = 10;
  localparam int BcdW    = 16;
  localparam int CharW   = 7;
  localparam int StepW   = 4;

  localparam logic [ExpW-1:0]  ExpAllOnes  = 11'h7FF;
  localparam logic [ExpW-1:0]  ExpBias     = 11'h3FF;
  localparam logic [StepW-1:0] DabbleSteps = 4'd10;

  localparam logic [CharW-1:0] ChMinus = 7'h2D;
  localparam logic [CharW-1:0] ChPlus  = 7'h2B;
  localparam logic [CharW-1:0] ChDot   = 7'h2E;
  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChOne   = 7'h31;
  localparam logic [CharW-1:0] ChX     = 7'h78;
  localparam logic [CharW-1:0] ChP     = 7'h70;
  localparam logic [CharW-1:0] ChI     = 7'h69;
  localparam logic [CharW-1:0] ChN     = 7'h6E;
  localparam logic [CharW-1:0] ChF     = 7'h66;
  localparam logic [CharW-1:0] ChA     = 7'h61;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MINUS,
    S_SPEC,
    S_ZERO,
    S_X,
    S_LEAD,
    S_DOT,
    S_FRAC,
    S_P,
    S_ESIGN,
    S_DIGIT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [MagW-1:0] mag;
  } bcd_req_t;

  typedef struct packed {
    logic            busy;
    logic [BcdW-1:0] digits;
  } bcd_stat_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) begin
      c = ChZero + {3'b000, nib};
    end else begin
      c = ChA - 7'd10 + {3'b000, nib};
    end
    return c;
  endfunction

  // "inf" or "nan" by position
  function automatic logic [CharW-1:0] spec_char(input logic is_nan, input logic [1:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      2'd0:    c = is_nan ? ChN : ChI;
      2'd1:    c = is_nan ? ChA : ChN;
      default: c = is_nan ? ChN : ChF;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/double_to_hex_float_text_unit.sv @@
// ----------------------------------------------------------------------------
// double_to_hex_float_text_unit
// formats a binary64 bit pattern as hex float text, one character per transaction
// ----------------------------------------------------------------------------
// the first character is registered after the sequencer leaves idle on the input transaction
// throughput: one character per cycle while out_ready is high; the exponent sign
//   waits on the 10-step bcd converter started at input
// one item at a time: in_ready is high only while the sequencer is idle
// reset: synchronous, clears sequencer state and the output valid
module double_to_hex_float_text_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dhft_pkg::BitsW-1:0]  bits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dhft_pkg::CharW-1:0]  char_code,
  output logic                        last
);
  import dhft_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [ExpW-1:0]  bexp;
  logic [FracW-1:0] frac;
  logic             is_nan;
  logic             eneg;
  logic [1:0]       spec_idx;
  logic [1:0]       dig_idx;
  logic [1:0]       top_idx;

  logic             accept;
  logic             can_load;
  logic             emit;
  logic [CharW-1:0] ch;
  logic             ch_last;

  logic [ExpW-1:0]  in_bexp;
  logic [ExpW-1:0]  in_diff;
  state_t           first_body;

  bcd_req_t         req;
  bcd_stat_t        stat;

  assign in_bexp = bits[BitsW-2 -: ExpW];
  assign in_diff = (in_bexp >= ExpBias) ? (in_bexp - ExpBias) : (ExpBias - in_bexp);
  assign accept  = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign can_load = !out_valid || out_ready;

  assign req.start = accept;
  assign req.mag   = (in_bexp == '0) ? '0 : in_diff[MagW-1:0];

  dhft_bcd u_bcd (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat)
  );

  always_comb begin
    if (stat.digits[15:12] != 4'd0) begin
      top_idx = 2'd3;
    end else if (stat.digits[11:8] != 4'd0) begin
      top_idx = 2'd2;
    end else if (stat.digits[7:4] != 4'd0) begin
      top_idx = 2'd1;
    end else begin
      top_idx = 2'd0;
    end
  end

  assign first_body = (bexp == ExpAllOnes) ? S_SPEC : S_ZERO;

  // character and emit control
  always_comb begin
    emit    = 1'b0;
    ch      = ChZero;
    ch_last = 1'b0;
    unique case (state)
      S_IDLE: begin
        emit = 1'b0;
      end
      S_MINUS: begin
        emit = can_load;
        ch   = ChMinus;
      end
      S_SPEC: begin
        emit    = can_load;
        ch      = spec_char(is_nan, spec_idx);
        ch_last = (spec_idx == 2'd2);
      end
      S_ZERO: begin
        emit = can_load;
        ch   = ChZero;
      end
      S_X: begin
        emit = can_load;
        ch   = ChX;
      end
      S_LEAD: begin
        emit = can_load;
        ch   = (bexp != '0) ? ChOne : ChZero;
      end
      S_DOT: begin
        emit = can_load;
        ch   = ChDot;
      end
      S_FRAC: begin
        emit = can_load;
        ch   = hex_char(frac[FracW-1 -: 4]);
      end
      S_P: begin
        emit = can_load;
        ch   = ChP;
      end
      S_ESIGN: begin
        emit = can_load && !stat.busy;
        ch   = eneg ? ChMinus : ChPlus;
      end
      S_DIGIT: begin
        emit    = can_load;
        ch      = ChZero + {3'b000, stat.digits[{dig_idx, 2'b00} +: 4]};
        ch_last = (dig_idx == 2'd0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (bits[BitsW-1]) begin
            state_next = S_MINUS;
          end else if (in_bexp == ExpAllOnes) begin
            state_next = S_SPEC;
          end else begin
            state_next = S_ZERO;
          end
        end
      end
      S_MINUS: if (emit) state_next = first_body;
      S_SPEC:  if (emit && spec_idx == 2'd2) state_next = S_IDLE;
      S_ZERO:  if (emit) state_next = S_X;
      S_X:     if (emit) state_next = S_LEAD;
      S_LEAD:  if (emit) state_next = (frac != '0) ? S_DOT : S_P;
      S_DOT:   if (emit) state_next = S_FRAC;
      S_FRAC:  if (emit && frac[FracW-5:0] == '0) state_next = S_P;
      S_P:     if (emit) state_next = S_ESIGN;
      S_ESIGN: if (emit) state_next = S_DIGIT;
      S_DIGIT: if (emit && dig_idx == 2'd0) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_code <= ch;
      last      <= ch_last;
    end
    if (accept) begin
      bexp     <= in_bexp;
      frac     <= bits[FracW-1:0];
      is_nan   <= (bits[FracW-1:0] != '0);
      eneg     <= (in_bexp != '0) && (in_bexp < ExpBias);
      spec_idx <= 2'd0;
    end else begin
      if (emit && state == S_SPEC) begin
        spec_idx <= spec_idx + 2'd1;
      end
      if (emit && state == S_FRAC) begin
        frac <= {frac[FracW-5:0], 4'h0};
      end
    end
    if (emit && state == S_ESIGN) begin
      dig_idx <= top_idx;
    end else if (emit && state == S_DIGIT) begin
      dig_idx <= dig_idx - 2'd1;
    end
  end

endmodule

@@ rtl/core/dhft_bcd.sv @@
// ----------------------------------------------------------------------------
// dhft_bcd
// iterative shift-and-add-3 binary to bcd converter for the exponent magnitude
// ----------------------------------------------------------------------------
module dhft_bcd (
  input  logic              clk,
  input  logic              rst,
  input  dhft_pkg::bcd_req_t  req,
  output dhft_pkg::bcd_stat_t stat
);
  import dhft_pkg::*;

  logic [StepW-1:0] cnt;
  logic             run;
  logic [MagW-1:0]  mag;
  logic [BcdW-1:0]  bcd;
  logic [BcdW-1:0]  adj;

  always_comb begin
    adj = bcd;
    for (int i = 0; i < BcdW / 4; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      run <= 1'b1;
      cnt <= DabbleSteps;
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == 4'd1) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mag <= req.mag;
      bcd <= '0;
    end else if (run) begin
      bcd <= {adj[BcdW-2:0], mag[MagW-1]};
      mag <= {mag[MagW-2:0], 1'b0};
    end
  end

  assign stat.busy   = run;
  assign stat.digits = bcd;

endmodule

@@ rtl/core/dhft_checker.sv @@
// ----------------------------------------------------------------------------
// dhft_checker
// port-level checks for the binary64 hex text unit
// ----------------------------------------------------------------------------
module dhft_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [dhft_pkg::BitsW-1:0] bits,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dhft_pkg::CharW-1:0] char_code,
  input logic                       last
);
  import dhft_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last))
    else $error("output transaction dropped or changed while stalled");

  // waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(bits))
    else $error("input transaction dropped or changed while waiting");

  // one value at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a value is in progress");

  // every character lies between '+' and 'x'
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code >= ChPlus) && (char_code <= ChX))
    else $error("character outside the hex float alphabet");

  // a new value cannot start before the previous text ended
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) && !$past(rst) |-> out_valid && last)
    else $error("input ready returned without a last character");

endmodule

bind double_to_hex_float_text_unit dhft_checker u_dhft_checker (.*);
